### hw/rtl/kmp_next_table_builder_assert.svh
// ----------------------------------------------------------------------------
// KMP next-table builder assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KMP_NEXT_TABLE_BUILDER_ASSERT_SVH
`define KMP_NEXT_TABLE_BUILDER_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define KMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The condition must never be true outside reset.
`define KMP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hw/rtl/kmp_pkg.sv
// ----------------------------------------------------------------------------
// KMP package
// Widths, limits and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package kmp_pkg;

  localparam int MAX_LEN = 1024;
  localparam int CHAR_W  = 8;
  localparam int POS_W   = 11;
  localparam int NEXT_W  = 10;
  localparam int ADDR_W  = $clog2(MAX_LEN);

  // Position reported for a character that does not fit in the store.
  localparam logic [POS_W-1:0] POS_OVF = POS_W'(MAX_LEN + 1);

  typedef struct packed {
    logic accept;  // take the input request this cycle
    logic step;    // one fallback comparison
    logic finish;  // write back and load the result register
  } kmp_cmd_t;

  typedef struct packed {
    logic acc_done;     // the accepted request needs no comparison
    logic search_done;  // the current comparison ends the search
    logic out_free;     // the result register can be loaded
  } kmp_stat_t;

endpackage

### hw/rtl/kmp_in_if.sv
// ----------------------------------------------------------------------------
// KMP input channel
// One pattern character per request with a start-of-pattern flag.
// ----------------------------------------------------------------------------
interface kmp_in_if import kmp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] pattern_char;
  logic              start_pattern;

  modport source (output valid, output pattern_char, output start_pattern, input ready);
  modport sink   (input valid, input pattern_char, input start_pattern, output ready);
endinterface

### hw/rtl/kmp_out_if.sv
// ----------------------------------------------------------------------------
// KMP result channel
// One next-table entry per request with its position and an overflow flag.
// ----------------------------------------------------------------------------
interface kmp_out_if import kmp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  char_position;
  logic [NEXT_W-1:0] next_value;
  logic              overflow;

  modport source (output valid, output char_position, output next_value,
                  output overflow, input ready);
  modport sink   (input valid, input char_position, input next_value,
                  input overflow, output ready);
endinterface

### hw/rtl/kmp_ctrl.sv
// ----------------------------------------------------------------------------
// KMP controller
// Sequences acceptance, the fallback search and the write-back of one request.
// ----------------------------------------------------------------------------
module kmp_ctrl import kmp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  kmp_stat_t stat_i,
  output kmp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o.accept = in_valid_i && (state_q == ST_IDLE);
    cmd_o.step   = (state_q == ST_SEARCH);
    cmd_o.finish = (state_q == ST_FINISH) && stat_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.acc_done ? ST_FINISH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (stat_i.search_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/kmp_dpath.sv
// ----------------------------------------------------------------------------
// KMP datapath
// Character and next-value stores, the fallback register and the result
// register.
// ----------------------------------------------------------------------------
module kmp_dpath import kmp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kmp_cmd_t          cmd_i,
  output kmp_stat_t         stat_o,
  input  logic [CHAR_W-1:0] pattern_char_i,
  input  logic              start_pattern_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [POS_W-1:0]  char_position_o,
  output logic [NEXT_W-1:0] next_value_o,
  output logic              overflow_o
);

  logic [CHAR_W-1:0] char_mem [MAX_LEN];
  logic [NEXT_W-1:0] next_mem [MAX_LEN];

  logic [POS_W-1:0]  count_q;
  logic              out_valid_q;

  logic [POS_W-1:0]  j_q;
  logic [CHAR_W-1:0] ch_q;
  logic              ovf_q;
  logic [NEXT_W-1:0] k_q;
  logic [NEXT_W-1:0] nv_q;
  logic [CHAR_W-1:0] last_char_q;
  logic [NEXT_W-1:0] last_next_q;
  logic [CHAR_W-1:0] rd_char_q;
  logic [NEXT_W-1:0] rd_next_q;
  logic [POS_W-1:0]  pos_out_q;
  logic [NEXT_W-1:0] nv_out_q;
  logic              ovf_out_q;

  logic [POS_W-1:0]  eff_count;
  logic              acc_ovf;
  logic              acc_first;
  logic [POS_W-1:0]  acc_j;
  logic [NEXT_W-1:0] k_init;
  logic              match;
  logic [NEXT_W-1:0] k_step;
  logic [ADDR_W-1:0] rd_addr;
  logic [POS_W-1:0]  wr_pos;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_en;

  // A start flag restarts the pattern before this character is placed.
  assign eff_count = start_pattern_i ? '0 : count_q;
  assign acc_ovf   = (eff_count >= POS_W'(MAX_LEN));
  assign acc_first = (eff_count == '0);
  assign acc_j     = eff_count + POS_W'(1);

  // The search starts from the previous entry; a value that would not lie
  // below the new position ends the search at once.
  always_comb begin
    if (acc_first || ({1'b0, last_next_q} >= acc_j)) begin
      k_init = '0;
    end else begin
      k_init = last_next_q;
    end
  end

  assign match  = (rd_char_q == last_char_q);
  assign k_step = (rd_next_q < k_q) ? rd_next_q : '0;

  assign rd_addr = cmd_i.accept ? ADDR_W'(k_init - NEXT_W'(1))
                                : ADDR_W'(k_step - NEXT_W'(1));

  assign wr_pos  = j_q - POS_W'(1);
  assign wr_addr = wr_pos[ADDR_W-1:0];
  assign wr_en   = cmd_i.finish && !ovf_q;

  always_comb begin
    stat_o.acc_done    = acc_ovf || (k_init == '0);
    stat_o.search_done = match || (k_step == '0);
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        count_q <= acc_ovf ? eff_count : acc_j;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      j_q   <= acc_j;
      ch_q  <= pattern_char_i;
      ovf_q <= acc_ovf;
      k_q   <= k_init;
      nv_q  <= (acc_ovf || acc_first) ? '0 : NEXT_W'(1);
    end else if (cmd_i.step) begin
      k_q <= k_step;
      if (match) begin
        nv_q <= k_q + NEXT_W'(1);
      end else if (k_step == '0) begin
        nv_q <= NEXT_W'(1);
      end
    end
    if (wr_en) begin
      last_char_q <= ch_q;
      last_next_q <= nv_q;
    end
    if (cmd_i.finish) begin
      pos_out_q <= j_q;
      nv_out_q  <= nv_q;
      ovf_out_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      char_mem[wr_addr] <= ch_q;
      next_mem[wr_addr] <= nv_q;
    end
    rd_char_q <= char_mem[rd_addr];
    rd_next_q <= next_mem[rd_addr];
  end

  assign out_valid_o     = out_valid_q;
  assign char_position_o = pos_out_q;
  assign next_value_o    = nv_out_q;
  assign overflow_o      = ovf_out_q;

endmodule

### hw/rtl/kmp_next_table_builder.sv
// ----------------------------------------------------------------------------
// KMP next-table builder
// Builds the 1-based KMP next table of a pattern, one character per request.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Carries
//  -------  ---  ------------------------------------------------------------
//  pat_i    in   pattern_char, start_pattern (first character of a pattern)
//  res_o    out  char_position, next_value, overflow
//
//  A request makes f fallback comparisons, where f is the number that it needs
//  (0 for the first character, for an overflow and when the previous entry is 0).
//  Each comparison is one registered read of the two stores, through their
//  single read port.
//  Reset is asynchronous and active low; it clears the position count and the
//  control state. The stores are not cleared: every entry is written before
//  it is read within a pattern.
//  A stalled result register holds the finished request until it is taken.
//
module kmp_next_table_builder import kmp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  kmp_in_if.sink    pat_i,
  kmp_out_if.source res_o
);

`include "kmp_next_table_builder_assert.svh"

  kmp_cmd_t  cmd;
  kmp_stat_t stat;

  // The controller owns the sequence; the datapath owns all storage.
  kmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pat_i.valid),
    .in_ready_o (pat_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kmp_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .pattern_char_i  (pat_i.pattern_char),
    .start_pattern_i (pat_i.start_pattern),
    .out_ready_i     (res_o.ready),
    .out_valid_o     (res_o.valid),
    .char_position_o (res_o.char_position),
    .next_value_o    (res_o.next_value),
    .overflow_o      (res_o.overflow)
  );

  // Only one request is in flight, so acceptance closes the input side.
  `KMP_ASSERT(a_one_in_flight, (pat_i.valid && pat_i.ready) |=> !pat_i.ready,
              "input accepted while a request is in flight")

  // An overflow result carries the fixed position and a zero entry.
  `KMP_ASSERT(a_ovf_fields, (res_o.valid && res_o.overflow) |->
              (res_o.char_position == POS_OVF && res_o.next_value == '0),
              "overflow result with wrong fields")

  // A stored entry always points below its own position.
  `KMP_ASSERT_NEVER(a_next_below_pos, res_o.valid && !res_o.overflow &&
                    ({1'b0, res_o.next_value} >= res_o.char_position),
                    "next value not below its position")

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// KMP next-table builder testbench
// Streams pattern characters into the builder through the request channel,
// predicts each next-table entry in step, and checks every returned result
// field by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import kmp_pkg::*;

  // Stimulus volume and run shaping.
  localparam int TOTAL_ITEMS   = 1600;   // stop adding patterns past this count
  localparam int LONG_LEN      = 1028;   // one pattern that runs past the store
  localparam int LONG_BREAK    = 700;    // odd character inside the long pattern
  localparam int QUIET_TAIL    = 120;    // no idling once this few requests remain
  localparam int HOLD_CYCLES   = 400;    // long result stall to back up the input
  localparam int HOLD_AFTER    = 200;    // results seen before that stall begins
  localparam int DRAIN_CYCLES  = 64;     // quiet cycles after the last result
  localparam int PRINT_CAP     = 50;     // mismatch lines printed at most

  // One pattern character as offered on the request channel.
  typedef struct packed {
    logic [CHAR_W-1:0] pattern_char;
    logic              start_pattern;
  } pat_req_t;

  // One next-table entry as returned on the result channel.
  typedef struct packed {
    logic [POS_W-1:0]  char_position;
    logic [NEXT_W-1:0] next_value;
    logic              overflow;
  } next_entry_t;

  // Clock and reset start at known levels before any process runs.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  kmp_in_if  pat_if ();
  kmp_out_if res_if ();

  kmp_next_table_builder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pat_i  (pat_if),
    .res_o  (res_if)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor state: our own copy of the pattern stores and the fill count.
  // --------------------------------------------------------------------------
  logic [CHAR_W-1:0] pat_chars     [1:MAX_LEN];
  logic [NEXT_W-1:0] pat_next_vals [1:MAX_LEN];
  int                pat_len = 0;

  // Requests waiting to be driven, and entries waiting to come back.
  pat_req_t    pattern_feed[$];
  next_entry_t next_entries_due[$];

  // Bookkeeping shared between the processes.
  int  feed_total       = 0;
  int  requests_taken   = 0;
  int  patterns_started = 0;
  int  results_checked  = 0;
  int  overflows_seen   = 0;
  int  top_next_seen    = 0;
  int  mismatches       = 0;
  bit  pat_taken        = 1'b0;  // the request on the wires went in at the last edge
  int  send_gap         = 0;
  int  take_gap         = 0;
  int  send_idle_pct    = 10;
  int  take_idle_pct    = 10;
  int  hold_left        = 0;
  bit  hold_done        = 1'b0;

  // Computes the next-table entry for one accepted character and updates the
  // predictor stores. A start flag, or the first character after reset, opens
  // a new pattern at position one, whose entry is always zero. Past the store
  // the character is dropped and an overflow entry comes back instead.
  function automatic next_entry_t predict_next_entry(pat_req_t req);
    next_entry_t       entry;
    int                pos;
    int                k;
    int                nk;
    logic [CHAR_W-1:0] prev;
    if (req.start_pattern) pat_len = 0;
    if (pat_len >= MAX_LEN) begin
      pat_len             = MAX_LEN;
      entry.char_position = POS_OVF;
      entry.next_value    = '0;
      entry.overflow      = 1'b1;
      return entry;
    end
    pos            = pat_len + 1;
    pat_chars[pos] = req.pattern_char;
    k              = 0;
    if (pos > 1) begin
      // Walk the failure links from the previous entry until the character
      // before this one extends a border, or no border is left. A link that
      // does not shrink k ends the walk, so it always terminates.
      prev = pat_chars[pos-1];
      k    = int'(pat_next_vals[pos-1]);
      while (k != 0) begin
        if (k >= pos) begin
          k = 0;
          break;
        end
        if (pat_chars[k] == prev) break;
        nk = int'(pat_next_vals[k]);
        k  = (nk < k) ? nk : 0;
      end
      k = k + 1;
    end
    pat_next_vals[pos]  = NEXT_W'(k);
    pat_len             = pos;
    entry.char_position = POS_W'(pos);
    entry.next_value    = NEXT_W'(k);
    entry.overflow      = 1'b0;
    return entry;
  endfunction

  // Prints one mismatch line (up to a cap) and counts it.
  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  task automatic queue_char(logic [CHAR_W-1:0] ch, logic start);
    pat_req_t req;
    req.pattern_char  = ch;
    req.start_pattern = start;
    pattern_feed.push_back(req);
  endtask

  // Directed opening: the first character after reset without a start flag,
  // byte extremes, a run of equal characters, a pattern whose entries need
  // several fallback steps, and back-to-back single-character patterns.
  task automatic load_directed();
    queue_char(8'h00, 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_char(8'h00, 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_char(8'h00, 1'b0);
    for (int i = 0; i < 4; i++) queue_char(8'h61, i == 0);
    queue_char(8'h61, 1'b1);
    queue_char(8'h61, 1'b0);
    queue_char(8'h62, 1'b0);
    queue_char(8'h61, 1'b0);
    queue_char(8'h61, 1'b0);
    queue_char(8'h61, 1'b0);
    queue_char(8'h62, 1'b0);
    queue_char(8'h7A, 1'b1);
    queue_char(8'h7A, 1'b1);
    queue_char(8'hFF, 1'b1);
  endtask

  // Random body. Most patterns are short and drawn from a tiny alphabet so
  // that borders and fallback chains are common; the rest use raw bytes. A
  // tenth of them carry no start flag and simply extend the pattern before.
  // One long pattern of equal characters with a single odd one fills the
  // store, forces a very long fallback chain and runs into overflow.
  task automatic load_random();
    int                len;
    bit                tiny_alpha;
    bit                long_done;
    logic [CHAR_W-1:0] sym_a;
    logic [CHAR_W-1:0] sym_b;
    logic [CHAR_W-1:0] sym_c;
    logic [CHAR_W-1:0] ch;
    long_done = 1'b0;
    while (pattern_feed.size() < TOTAL_ITEMS) begin
      sym_a = CHAR_W'($urandom);
      sym_b = CHAR_W'($urandom);
      sym_c = CHAR_W'($urandom);
      if (!long_done && pattern_feed.size() >= 250) begin
        long_done = 1'b1;
        for (int i = 1; i <= LONG_LEN; i++) begin
          queue_char((i == LONG_BREAK) ? ~sym_a : sym_a, i == 1);
        end
      end else begin
        len        = $urandom_range(1, 40);
        tiny_alpha = ($urandom_range(0, 9) < 7);
        for (int i = 0; i < len; i++) begin
          if (!tiny_alpha) begin
            ch = CHAR_W'($urandom_range(0, 255));
          end else begin
            case ($urandom_range(0, 5))
              4:       ch = sym_b;
              5:       ch = sym_c;
              default: ch = sym_a;
            endcase
          end
          queue_char(ch, (i == 0) && ($urandom_range(0, 9) != 0));
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driver. Inputs change on the falling edge. A request stays on the
  // wires until the rising edge that takes it; between requests the driver
  // may go quiet for a burst of idle cycles. The idle rate drifts between
  // none, light and heavy, and drops to none for the tail of the run.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_requests
    pat_req_t req;
    if ($urandom_range(0, 199) == 0) begin
      case ($urandom_range(0, 2))
        0:       send_idle_pct = 0;
        1:       send_idle_pct = 10;
        default: send_idle_pct = 35;
      endcase
    end
    if (!rst_ni) begin
      pat_if.valid         <= 1'b0;
      pat_if.pattern_char  <= '0;
      pat_if.start_pattern <= 1'b0;
    end else if (pat_if.valid && !pat_taken) begin
      // Request still waiting for the block: hold it unchanged.
    end else if (send_gap > 0) begin
      send_gap     <= send_gap - 1;
      pat_if.valid <= 1'b0;
    end else if (pattern_feed.size() == 0) begin
      pat_if.valid <= 1'b0;
    end else if (pattern_feed.size() > QUIET_TAIL &&
                 $urandom_range(0, 99) < send_idle_pct) begin
      send_gap     <= $urandom_range(0, 13);
      pat_if.valid <= 1'b0;
    end else begin
      req                  = pattern_feed.pop_front();
      pat_if.valid         <= 1'b1;
      pat_if.pattern_char  <= req.pattern_char;
      pat_if.start_pattern <= req.start_pattern;
    end
  end

  // Long result stall, counted here on its own: once enough results have
  // gone by, ready is held low while the driver keeps offering, so the
  // result register and then the input back up.
  always @(negedge clk_i) begin : pressure_hold
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (!hold_done && results_checked >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result ready driver, with its own bursts of stalled cycles.
  always @(negedge clk_i) begin : drive_ready
    if ($urandom_range(0, 199) == 0) begin
      case ($urandom_range(0, 2))
        0:       take_idle_pct = 0;
        1:       take_idle_pct = 10;
        default: take_idle_pct = 35;
      endcase
    end
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_if.ready <= 1'b0;
    end else if (take_gap > 0) begin
      take_gap     <= take_gap - 1;
      res_if.ready <= 1'b0;
    end else if (pattern_feed.size() > QUIET_TAIL &&
                 $urandom_range(0, 99) < take_idle_pct) begin
      take_gap     <= $urandom_range(0, 13);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. On each rising edge an accepted request is run through the
  // predictor and its entry queued; an accepted result is compared with the
  // oldest queued entry. The block returns exactly one result per request,
  // in order, so a plain queue is enough.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_channels
    pat_req_t    req;
    next_entry_t got;
    next_entry_t want;
    if (rst_ni) begin
      pat_taken <= pat_if.valid && pat_if.ready;
      if (pat_if.valid && pat_if.ready) begin
        req.pattern_char  = pat_if.pattern_char;
        req.start_pattern = pat_if.start_pattern;
        next_entries_due.push_back(predict_next_entry(req));
        requests_taken++;
        if (req.start_pattern) patterns_started++;
      end
      if (res_if.valid && res_if.ready) begin
        got.char_position = res_if.char_position;
        got.next_value    = res_if.next_value;
        got.overflow      = res_if.overflow;
        results_checked++;
        if (next_entries_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: pos %0d next %0d ovf %0b",
                                    got.char_position, got.next_value, got.overflow));
        end else begin
          want = next_entries_due.pop_front();
          if (got.char_position !== want.char_position)
            report_mismatch($sformatf("char_position %0d, expected %0d",
                                      got.char_position, want.char_position));
          if (got.next_value !== want.next_value)
            report_mismatch($sformatf("next_value %0d at position %0d, expected %0d",
                                      got.next_value, want.char_position, want.next_value));
          if (got.overflow !== want.overflow)
            report_mismatch($sformatf("overflow %0b at position %0d, expected %0b",
                                      got.overflow, want.char_position, want.overflow));
          if (want.overflow) overflows_seen++;
          if (int'(want.next_value) > top_next_seen) top_next_seen = int'(want.next_value);
        end
      end
    end
  end

  // Hard stop for a hung block; far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("kmp_next_table_builder verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, build the stimulus, wait for every request to go
  // in and every entry to come back, then let the block sit quiet for a
  // while so that a stray extra result would still be caught.
  // --------------------------------------------------------------------------
  initial begin
    load_directed();
    load_random();
    feed_total = pattern_feed.size();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (requests_taken == feed_total);
    wait (next_entries_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d characters over %0d flagged patterns; %0d results checked.",
             requests_taken, patterns_started, results_checked);
    $display("Overflow entries: %0d, largest next value: %0d, mismatches: %0d.",
             overflows_seen, top_next_seen, mismatches);
    if (mismatches == 0) begin
      $display("kmp_next_table_builder verification clean");
    end else begin
      $display("kmp_next_table_builder verification failed");
    end
    $finish;
  end

endmodule
